[hdl/rhtt_pkg.sv]
// shared types and constants for the rectangle hit test table
`default_nettype none

package rhtt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int COORD_W = 16;
  localparam int TAG_W   = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TEST  = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // one table entry, x in the low bits
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

endpackage

`default_nettype wire

[hdl/rhtt_if.sv]
// request and response channel interfaces
`default_nettype none

interface rhtt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] rect_w;
  logic [15:0] rect_h;
  logic [15:0] action_tag;

  modport source (output valid, operation, pos_x, pos_y, rect_w, rect_h, action_tag,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, rect_w, rect_h, action_tag,
                output ready);
endinterface

interface rhtt_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] found_tag;
  logic        add_dropped;

  modport source (output valid, hit, found_tag, add_dropped, input ready);
  modport sink (input valid, hit, found_tag, add_dropped, output ready);
endinterface

`default_nettype wire

[hdl/rhtt_ram.sv]
// simple dual-port ram, one write port, one registered read port
`default_nettype none

module rhtt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/rhtt_ctrl.sv]
// sequencer: entry count, newest-first scan, containment compare, result register
`default_nettype none

module rhtt_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rhtt_in_if.sink                            req,
  rhtt_out_if.source                         rsp,
  output rhtt_pkg::ram_wr_t                  wr,
  output logic [rhtt_pkg::IDX_W-1:0]         raddr,
  input  wire rhtt_pkg::entry_t              rdata
);

  rhtt_pkg::state_t state, state_next;

  logic [rhtt_pkg::CNT_W-1:0]   count;
  logic [rhtt_pkg::CNT_W-1:0]   cnt_m1;
  logic [rhtt_pkg::IDX_W-1:0]   scan_idx;
  logic [rhtt_pkg::IDX_W-1:0]   scan_m1;
  logic [rhtt_pkg::COORD_W-1:0] px;
  logic [rhtt_pkg::COORD_W-1:0] py;

  logic                       out_vld;
  logic                       out_hit;
  logic [rhtt_pkg::TAG_W-1:0] out_tag;
  logic                       out_drop;

  logic                       slot_free;
  logic                       take;
  logic                       is_full;
  logic                       match;
  logic                       last;
  logic                       load_out;
  logic                       res_hit;
  logic [rhtt_pkg::TAG_W-1:0] res_tag;
  logic                       res_drop;
  logic [rhtt_pkg::COORD_W:0] x_end;
  logic [rhtt_pkg::COORD_W:0] y_end;

  assign slot_free = !out_vld || rsp.ready;
  assign req.ready = (state == rhtt_pkg::ST_IDLE) && slot_free;
  assign take      = req.valid && req.ready;
  assign is_full   = (count == rhtt_pkg::CNT_W'(rhtt_pkg::ENTRIES));
  assign cnt_m1    = count - rhtt_pkg::CNT_W'(1);
  assign scan_m1   = scan_idx - rhtt_pkg::IDX_W'(1);
  assign last      = (scan_idx == '0);

  // 17-bit bounds so x + w never wraps
  assign x_end = {1'b0, rdata.x} + {1'b0, rdata.w};
  assign y_end = {1'b0, rdata.y} + {1'b0, rdata.h};
  assign match = (px >= rdata.x) && ({1'b0, px} < x_end) &&
                 (py >= rdata.y) && ({1'b0, py} < y_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhtt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    wr.en        = 1'b0;
    wr.addr      = count[rhtt_pkg::IDX_W-1:0];
    wr.data.tag  = req.action_tag;
    wr.data.h    = req.rect_h;
    wr.data.w    = req.rect_w;
    wr.data.y    = req.pos_y;
    wr.data.x    = req.pos_x;
    raddr        = cnt_m1[rhtt_pkg::IDX_W-1:0];
    load_out     = 1'b0;
    res_hit      = 1'b0;
    res_tag      = '0;
    res_drop     = 1'b0;
    case (state)
      rhtt_pkg::ST_IDLE: begin
        if (take) begin
          case (req.operation)
            rhtt_pkg::OP_ADD: begin
              load_out = 1'b1;
              if (is_full) begin
                res_drop = 1'b1;
              end else begin
                wr.en = 1'b1;
              end
            end
            rhtt_pkg::OP_TEST: begin
              if (count == '0) begin
                load_out = 1'b1;
              end else begin
                state_next = rhtt_pkg::ST_SCAN;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      rhtt_pkg::ST_SCAN: begin
        raddr = scan_m1;
        if (match) begin
          load_out   = 1'b1;
          res_hit    = 1'b1;
          res_tag    = rdata.tag;
          state_next = rhtt_pkg::ST_IDLE;
        end else if (last) begin
          load_out   = 1'b1;
          state_next = rhtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rhtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      out_vld <= 1'b0;
    end else begin
      if (take && (req.operation == rhtt_pkg::OP_CLEAR)) begin
        count <= '0;
      end else if (wr.en) begin
        count <= count + rhtt_pkg::CNT_W'(1);
      end
      if (load_out) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px       <= req.pos_x;
      py       <= req.pos_y;
      scan_idx <= cnt_m1[rhtt_pkg::IDX_W-1:0];
    end else if (state == rhtt_pkg::ST_SCAN) begin
      scan_idx <= scan_m1;
    end
    if (load_out) begin
      out_hit  <= res_hit;
      out_tag  <= res_tag;
      out_drop <= res_drop;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.hit         = out_hit;
  assign rsp.found_tag   = out_tag;
  assign rsp.add_dropped = out_drop;

endmodule

`default_nettype wire

[hdl/rect_hit_test_table.sv]
// top level of the rectangle hit test table
// clear, add and unused codes give their result in the cycle after the transfer
// a test answers in the cycle after the transfer on an empty table, else after its scan
// throughput: one non-test item per cycle while the receiver takes results; a test holds the input for its whole scan
// the scan reads one entry per cycle through the single ram read port
// reset: synchronous, empties the table and drops any pending result; no clearing pass
`default_nettype none

module rect_hit_test_table (
  input  wire logic  clk,
  input  wire logic  rst,
  rhtt_in_if.sink    req,
  rhtt_out_if.source rsp
);

  // write command from the sequencer into the table memory
  rhtt_pkg::ram_wr_t            wr;
  // read address driven every cycle, data comes back in the following cycle
  logic [rhtt_pkg::IDX_W-1:0]   raddr;
  logic [$bits(rhtt_pkg::entry_t)-1:0] rdata_raw;
  rhtt_pkg::entry_t             rdata;

  assign rdata = rhtt_pkg::entry_t'(rdata_raw);

  // sequencer: owns the entry count, walks entries newest to oldest on a test,
  // stops on the first containing rectangle, and holds the result register
  rhtt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // table memory: rectangle and tag side by side in one word per entry,
  // never written and read at the same entry in one cycle: the idle read
  // sits one below the write slot and a test scan blocks adds
  rhtt_ram #(
    .DEPTH (rhtt_pkg::ENTRIES),
    .WIDTH ($bits(rhtt_pkg::entry_t)),
    .AW    (rhtt_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

endmodule

`default_nettype wire

[hdl/rhtt_checker.sv]
// port-level checks for the rectangle hit test table, bound to the top level
`default_nettype none

module rhtt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [15:0] out_found_tag,
  input wire logic        out_add_dropped
);

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_found_tag) && $stable(out_add_dropped))
    else $error("stalled result changed");

  // a miss carries a zero tag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_found_tag == '0)
    else $error("miss with nonzero tag");

  // a result is never both a hit and a dropped add
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_add_dropped))
    else $error("hit and drop together");

  // a clear answers all zeros in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_operation == rhtt_pkg::OP_CLEAR) |=>
      out_valid && !out_hit && !out_add_dropped && (out_found_tag == '0))
    else $error("clear result wrong or late");

endmodule

bind rect_hit_test_table rhtt_checker u_rhtt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .in_operation    (req.operation),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .out_hit         (rsp.hit),
  .out_found_tag   (rsp.found_tag),
  .out_add_dropped (rsp.add_dropped)
);

`default_nettype wire

[tb/tb_rect_hit_test_table.sv]
// testbench for the rectangle hit test table: directed and random tests against an inline table model
module tb_rect_hit_test_table;

  // operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  // well above the slowest correct run: ~575 transfers, each up to a full
  // 64 entry scan, a long receiver stall and a long sender gap
  localparam int         CYCLE_LIMIT = 500000;
  // room for a test that scans a full table, and margin after that
  localparam int         TAIL_CYCLES = rhtt_pkg::ENTRIES + 8;
  // cap on printed mismatch lines, all of them are still counted
  localparam int         MAX_PRINTED = 40;

  typedef struct {
    logic [1:0]                   op;
    logic [rhtt_pkg::COORD_W-1:0] x;
    logic [rhtt_pkg::COORD_W-1:0] y;
    logic [rhtt_pkg::COORD_W-1:0] w;
    logic [rhtt_pkg::COORD_W-1:0] h;
    logic [rhtt_pkg::TAG_W-1:0]   tag;
  } req_item_t;

  typedef struct {
    logic                       hit;
    logic [rhtt_pkg::TAG_W-1:0] tag;
    logic                       dropped;
  } hit_result_t;

  logic clk;
  logic rst;

  rhtt_in_if  req_if ();
  rhtt_out_if rsp_if ();

  rect_hit_test_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // shadow copy of the rectangle table, updated at each request transfer
  logic [rhtt_pkg::COORD_W-1:0] tbl_x   [rhtt_pkg::ENTRIES];
  logic [rhtt_pkg::COORD_W-1:0] tbl_y   [rhtt_pkg::ENTRIES];
  logic [rhtt_pkg::COORD_W-1:0] tbl_w   [rhtt_pkg::ENTRIES];
  logic [rhtt_pkg::COORD_W-1:0] tbl_h   [rhtt_pkg::ENTRIES];
  logic [rhtt_pkg::TAG_W-1:0]   tbl_tag [rhtt_pkg::ENTRIES];
  int                           tbl_count = 0;

  // responses still owed by the block, oldest first
  hit_result_t pending_results[$];
  hit_result_t want;

  int errors = 0;
  int cycles = 0;

  // idling knobs, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // what the run went through, for the closing summary
  int n_items   = 0;
  int n_adds    = 0;
  int n_dropped = 0;
  int n_tests   = 0;
  int n_hits    = 0;
  int n_clears  = 0;
  int n_unused  = 0;

  // 4 time unit clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // free running cycle count doubles as the watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d responses outstanding",
               cycles, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // response checker: every response transfer is matched against the oldest
  // expectation, field by field
  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected response hit=%b tag=%h dropped=%b",
                                  rsp_if.hit, rsp_if.found_tag, rsp_if.add_dropped));
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", rsp_if.hit, want.hit));
        if (rsp_if.found_tag !== want.tag)
          report_mismatch($sformatf("found_tag %h, expected %h", rsp_if.found_tag, want.tag));
        if (rsp_if.add_dropped !== want.dropped)
          report_mismatch($sformatf("add_dropped %b, expected %b",
                                    rsp_if.add_dropped, want.dropped));
      end
    end
  end

  // span check in 32 bit int arithmetic: lo <= p < lo + len, no wrap at the top of the screen
  function automatic bit in_span(logic [rhtt_pkg::COORD_W-1:0] lo,
                                 logic [rhtt_pkg::COORD_W-1:0] len,
                                 logic [rhtt_pkg::COORD_W-1:0] p);
    return (int'(p) >= int'(lo)) && (int'(p) < int'(lo) + int'(len));
  endfunction

  // applies one request to the shadow table and returns the response it owes
  function automatic hit_result_t predict_hit_result(req_item_t it);
    hit_result_t r;
    int          i;
    r.hit     = 1'b0;
    r.tag     = '0;
    r.dropped = 1'b0;
    case (it.op)
      rhtt_pkg::OP_CLEAR: begin
        tbl_count = 0;
        n_clears++;
      end
      rhtt_pkg::OP_ADD: begin
        n_adds++;
        if (tbl_count >= rhtt_pkg::ENTRIES) begin
          // table full: nothing stored
          r.dropped = 1'b1;
          n_dropped++;
        end else begin
          tbl_x[tbl_count]   = it.x;
          tbl_y[tbl_count]   = it.y;
          tbl_w[tbl_count]   = it.w;
          tbl_h[tbl_count]   = it.h;
          tbl_tag[tbl_count] = it.tag;
          tbl_count++;
        end
      end
      rhtt_pkg::OP_TEST: begin
        n_tests++;
        // newest entry first, the first containing rectangle wins
        for (i = tbl_count - 1; i >= 0 && !r.hit; i--) begin
          if (in_span(tbl_x[i], tbl_w[i], it.x) && in_span(tbl_y[i], tbl_h[i], it.y)) begin
            r.hit = 1'b1;
            r.tag = tbl_tag[i];
          end
        end
        if (r.hit) n_hits++;
      end
      default: begin
        // unused code leaves the table alone and answers all zeros
        n_unused++;
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] urange16(int lo, int hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[15:0];
  endfunction

  function automatic logic [15:0] rnd16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic req_item_t make_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                          logic [15:0] w, logic [15:0] h,
                                          logic [15:0] tag);
    req_item_t it;
    it.op  = op;
    it.x   = x;
    it.y   = y;
    it.w   = w;
    it.h   = h;
    it.tag = tag;
    return it;
  endfunction

  // random add: mostly small rectangles in a crowded corner so that tests hit,
  // some hugging the far screen edge, some anywhere
  function automatic req_item_t rand_add();
    req_item_t it;
    int        sel;
    sel    = $urandom_range(99);
    it.op  = rhtt_pkg::OP_ADD;
    it.tag = rnd16();
    if (sel < 75) begin
      it.x = urange16(0, 63);
      it.y = urange16(0, 63);
      it.w = urange16(0, 24);
      it.h = urange16(0, 24);
    end else if (sel < 88) begin
      it.x = urange16(65535 - 40, 65535);
      it.y = urange16(65535 - 40, 65535);
      it.w = ($urandom_range(1) == 0) ? rnd16() : urange16(0, 48);
      it.h = ($urandom_range(1) == 0) ? rnd16() : urange16(0, 48);
    end else begin
      it.x = rnd16();
      it.y = rnd16();
      it.w = rnd16();
      it.h = rnd16();
    end
    return it;
  endfunction

  // coordinate on or just around one span: below, at the end, or inside
  function automatic logic [15:0] pick_coord(logic [15:0] lo, logic [15:0] len);
    int top;
    int hi;
    int k;
    k   = $urandom_range(3);
    top = int'(lo) + int'(len);
    if (k == 0 && lo != 0) return lo - 16'd1;
    if (k == 1 && top <= 65535) return top[15:0];
    if (len == 0) return lo;
    hi = (top - 1 > 65535) ? 65535 : top - 1;
    return urange16(int'(lo), hi);
  endfunction

  // random test point: mostly aimed at a live entry or its borders
  function automatic req_item_t rand_test();
    req_item_t it;
    int        sel;
    int        idx;
    sel    = $urandom_range(99);
    it.op  = rhtt_pkg::OP_TEST;
    // fields a test does not use carry junk
    it.w   = rnd16();
    it.h   = rnd16();
    it.tag = rnd16();
    if (tbl_count > 0 && sel < 60) begin
      idx  = $urandom_range(tbl_count - 1);
      it.x = pick_coord(tbl_x[idx], tbl_w[idx]);
      it.y = pick_coord(tbl_y[idx], tbl_h[idx]);
    end else if (sel < 85) begin
      it.x = urange16(0, 95);
      it.y = urange16(0, 95);
    end else if (sel < 93) begin
      it.x = urange16(65535 - 63, 65535);
      it.y = urange16(65535 - 63, 65535);
    end else begin
      it.x = rnd16();
      it.y = rnd16();
    end
    return it;
  endfunction

  // one request transfer; called and returns on a falling edge, valid is left
  // high so back to back transfers need no second assignment in one step
  task automatic send_item(req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= it.op;
    req_if.pos_x      <= it.x;
    req_if.pos_y      <= it.y;
    req_if.rect_w     <= it.w;
    req_if.rect_h     <= it.h;
    req_if.action_tag <= it.tag;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_results.push_back(predict_hit_result(it));
    n_items++;
    @(negedge clk);
  endtask

  // sender holds off until every owed response has been seen
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // empty table, unused code, zero sized rectangle
  task automatic test_empty_and_unused();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(make_item(rhtt_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff));
    send_item(make_item(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    // a rectangle with no area never contains its own corner
    send_item(make_item(rhtt_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0005,
                        16'h1234));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
    wait_results_drained();
  endtask

  // inclusive left and top edges, exclusive right and bottom, newest wins,
  // rectangles that run past the screen edge, a hit whose tag is zero
  task automatic test_bounds_and_priority();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    send_item(make_item(rhtt_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
    send_item(make_item(rhtt_pkg::OP_ADD, 16'd10, 16'd20, 16'd5, 16'd3, 16'h1111));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd9, 16'd20, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd10, 16'd20, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd14, 16'd22, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd15, 16'd22, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd14, 16'd23, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd10, 16'd19, 16'h0000, 16'h0000, 16'h0000));
    // newer one cell rectangle inside the first
    send_item(make_item(rhtt_pkg::OP_ADD, 16'd12, 16'd21, 16'd1, 16'd1, 16'h2222));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd12, 16'd21, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd13, 16'd21, 16'h0000, 16'h0000, 16'h0000));
    // far corner with maximum size: the end must not wrap to zero
    send_item(make_item(rhtt_pkg::OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff));
    send_item(make_item(rhtt_pkg::OP_ADD, 16'h0000, 16'h0000, 16'hffff, 16'hffff,
                        16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'hffff, 16'hffff, 16'h0000, 16'h0000,
                        16'h0000));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'hfffe, 16'hfffe, 16'h0000, 16'h0000,
                        16'h0000));
    wait_results_drained();
  endtask

  // fill every entry, overflow it, then hit only the oldest entry so the
  // scan runs the whole table
  task automatic test_table_full();
    int i;
    send_idle_pct  = 66;
    recv_stall_pct = 66;
    send_item(make_item(rhtt_pkg::OP_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
    send_item(make_item(rhtt_pkg::OP_ADD, 16'd60000, 16'd60000, 16'd10, 16'd10, rnd16()));
    for (i = 1; i < rhtt_pkg::ENTRIES; i++) begin
      send_item(make_item(rhtt_pkg::OP_ADD, urange16(0, 63), urange16(0, 63),
                          urange16(0, 24), urange16(0, 24), rnd16()));
    end
    for (i = 0; i < 3; i++) begin
      send_item(make_item(rhtt_pkg::OP_ADD, rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
    end
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd60005, 16'd60009, rnd16(), rnd16(),
                        rnd16()));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd60010, 16'd60000, rnd16(), rnd16(),
                        rnd16()));
    send_item(rand_test());
    // after a clear the table takes adds again
    send_item(make_item(rhtt_pkg::OP_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
    send_item(make_item(rhtt_pkg::OP_ADD, 16'd60000, 16'd60000, 16'd10, 16'd10, rnd16()));
    send_item(make_item(rhtt_pkg::OP_TEST, 16'd60005, 16'd60009, rnd16(), rnd16(),
                        rnd16()));
    wait_results_drained();
  endtask

  // scenes: a clear, then a run of adds and tests with random content; a few
  // long add-heavy scenes fill the table, some scenes skip the clear
  task automatic test_random_scenes(int n_target, int idle_pct, int stall_pct);
    int sent;
    int scene_len;
    int add_pct;
    int sel;
    int j;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    while (sent < n_target) begin
      if ($urandom_range(99) < 85) begin
        send_item(make_item(rhtt_pkg::OP_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(),
                            rnd16()));
        sent++;
      end
      if ($urandom_range(9) == 0) begin
        scene_len = $urandom_range(100, 80);
        add_pct   = 75;
      end else begin
        scene_len = $urandom_range(30, 4);
        add_pct   = 45;
      end
      for (j = 0; j < scene_len && sent < n_target; j++) begin
        sel = $urandom_range(99);
        if (sel < 3)
          send_item(make_item(OP_UNUSED, rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
        else if (sel < add_pct)
          send_item(rand_add());
        else
          send_item(rand_test());
        sent++;
      end
    end
    wait_results_drained();
  endtask

  initial begin
    // every block input known from time zero
    rst                  = 1'b1;
    req_if.valid         = 1'b0;
    req_if.operation     = rhtt_pkg::OP_CLEAR;
    req_if.pos_x         = '0;
    req_if.pos_y         = '0;
    req_if.rect_w        = '0;
    req_if.rect_h        = '0;
    req_if.action_tag    = '0;
    rsp_if.ready         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_unused();
    test_bounds_and_priority();
    test_table_full();
    test_random_scenes(120, 0, 0);
    test_random_scenes(120, 66, 0);
    test_random_scenes(120, 0, 66);
    test_random_scenes(120, 22, 22);

    // all expectations met, give a late or extra response time to show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transfers in %0d cycles: %0d adds (%0d dropped), %0d clears,",
             n_items, cycles, n_adds, n_dropped, n_clears);
    $display("%0d point tests (%0d hits), %0d unused codes, %0d mismatches",
             n_tests, n_hits, n_unused, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rhtt_pkg.sv
hdl/rhtt_if.sv
hdl/rhtt_ram.sv
hdl/rhtt_ctrl.sv
hdl/rect_hit_test_table.sv
hdl/rhtt_checker.sv
tb/tb_rect_hit_test_table.sv
